/* rtl/core/ocs_pkg.sv */
// Shared types and constants for the overlap crossfade stitcher.
// No dependencies; every other file of the block but ocs_ram refers to this package.
package ocs_pkg;

	localparam int CHANNELS = 2;
	localparam int SAMPLE_W = 16;
	localparam int FRAME_W  = CHANNELS * SAMPLE_W;
	localparam int CFG_W    = 13;
	localparam int QW       = 17; // quotient bits of the blend divide
	localparam int QCW      = $clog2(QW);

	localparam logic [CFG_W-1:0] OVERLAP_RESET = 13'd4096;

	localparam logic [QW-1:0] Q_POS_MAX = 17'd32767;
	localparam logic [QW-1:0] Q_NEG_MAX = 17'd32768;
	localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_LO = 16'sh8000;

	localparam logic FUNC_FRAME = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_RDWAIT,
		S_BLEND0,
		S_BLEND1,
		S_WRITE,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		M_DRAIN,
		M_BLEND,
		M_SWAP,
		M_PUSH
	} mode_t;

	typedef enum logic [2:0] {
		BL_IDLE,
		BL_MUL1,
		BL_MUL2,
		BL_PREP,
		BL_DIV,
		BL_FIN
	} bl_state_t;

	// handshake between the sequencer and the blend unit
	typedef struct packed {
		logic start;
		logic ch_sel;
	} bl_ctl_t;

endpackage

/* rtl/core/ocs_if.sv */
// Valid/ready channel interfaces for input frames and emitted frames.
// Depends on ocs_pkg for the sample width.
interface ocs_in_if;
	logic valid;
	logic ready;
	logic func;
	logic batch_start;
	logic signed [ocs_pkg::SAMPLE_W-1:0] sample_ch0;
	logic signed [ocs_pkg::SAMPLE_W-1:0] sample_ch1;

	modport source (output valid, func, batch_start, sample_ch0, sample_ch1, input ready);
	modport sink (input valid, func, batch_start, sample_ch0, sample_ch1, output ready);
endinterface

interface ocs_out_if;
	logic valid;
	logic ready;
	logic signed [ocs_pkg::SAMPLE_W-1:0] out_ch0;
	logic signed [ocs_pkg::SAMPLE_W-1:0] out_ch1;
	logic drain_last;
	logic short_batch_error;

	modport source (output valid, out_ch0, out_ch1, drain_last, short_batch_error, input ready);
	modport sink (input valid, out_ch0, out_ch1, drain_last, short_batch_error, output ready);
endinterface

/* rtl/core/ocs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ocs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/ocs_blend.sv */
// Serial blend unit: (nw*idx + old*(p-idx)) / p, rounded half away from zero.
// One shared multiplier in states BL_MUL1 and BL_MUL2, then a restoring divide, one bit a cycle.
// Depends on ocs_pkg.
module ocs_blend #(
	parameter int PW = 13
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [ocs_pkg::SAMPLE_W-1:0]  nw,
	input  logic signed [ocs_pkg::SAMPLE_W-1:0]  old,
	input  logic [PW-1:0]                        idx,
	input  logic [PW-1:0]                        p,
	output logic                                 done,
	output logic signed [ocs_pkg::SAMPLE_W-1:0]  res
);

	localparam int AWD = PW + 18; // accumulator / dividend width
	localparam int DW  = PW + 1;  // divisor 2p
	localparam int RW  = PW + 2;  // partial remainder with shifted-in bit

	ocs_pkg::bl_state_t st_q, st_d;

	logic signed [ocs_pkg::SAMPLE_W-1:0] nw_q, old_q;
	logic [PW-1:0]                       idx_q, p_q;
	logic signed [AWD-1:0]               acc_q;
	logic                                neg_q;
	logic [RW-1:0]                       rem_q;
	logic [ocs_pkg::QW-1:0]              nq_q;
	logic [ocs_pkg::QCW-1:0]             cnt_q;

	logic signed [ocs_pkg::SAMPLE_W-1:0] mul_a;
	logic [PW-1:0]                       mul_b;
	logic signed [AWD-1:0]               prod;
	logic [AWD-1:0]                      mag;
	logic [AWD-1:0]                      dvd;
	logic [DW-1:0]                       dvs;
	logic [RW-1:0]                       trial;
	logic                                ge;

	assign mul_a = (st_q == ocs_pkg::BL_MUL1) ? old_q : nw_q;
	assign mul_b = (st_q == ocs_pkg::BL_MUL1) ? (p_q - idx_q) : idx_q;
	assign prod  = AWD'($signed({mul_a[ocs_pkg::SAMPLE_W-1], mul_a}))
		* AWD'($signed({1'b0, mul_b}));

	assign mag   = acc_q[AWD-1] ? AWD'(-acc_q) : AWD'(acc_q);
	assign dvd   = (mag << 1) + AWD'(p_q);
	assign dvs   = {p_q, 1'b0};
	assign trial = {rem_q[RW-2:0], nq_q[ocs_pkg::QW-1]};
	assign ge    = trial >= RW'(dvs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ocs_pkg::BL_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		done = 1'b0;
		unique case (st_q)
			ocs_pkg::BL_IDLE: begin
				if (start) st_d = ocs_pkg::BL_MUL1;
			end
			ocs_pkg::BL_MUL1: st_d = ocs_pkg::BL_MUL2;
			ocs_pkg::BL_MUL2: st_d = ocs_pkg::BL_PREP;
			ocs_pkg::BL_PREP: st_d = ocs_pkg::BL_DIV;
			ocs_pkg::BL_DIV: begin
				if (cnt_q == '0) st_d = ocs_pkg::BL_FIN;
			end
			ocs_pkg::BL_FIN: begin
				done = 1'b1;
				st_d = start ? ocs_pkg::BL_MUL1 : ocs_pkg::BL_IDLE;
			end
			default: st_d = ocs_pkg::BL_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && (st_q == ocs_pkg::BL_IDLE || st_q == ocs_pkg::BL_FIN)) begin
			nw_q  <= nw;
			old_q <= old;
			idx_q <= idx;
			p_q   <= p;
		end
		case (st_q)
			ocs_pkg::BL_MUL1: acc_q <= prod;
			ocs_pkg::BL_MUL2: acc_q <= acc_q + prod;
			ocs_pkg::BL_PREP: begin
				neg_q <= acc_q[AWD-1];
				// dividend < 2p * 2^QW, so the top part is already below the divisor
				rem_q <= RW'(dvd >> ocs_pkg::QW);
				nq_q  <= dvd[ocs_pkg::QW-1:0];
				cnt_q <= ocs_pkg::QCW'(ocs_pkg::QW - 1);
			end
			ocs_pkg::BL_DIV: begin
				rem_q <= ge ? (trial - RW'(dvs)) : trial;
				nq_q  <= {nq_q[ocs_pkg::QW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (neg_q) begin
			res = (nq_q > ocs_pkg::Q_NEG_MAX) ? ocs_pkg::SAT_LO
				: ocs_pkg::SAMPLE_W'(-nq_q);
		end else begin
			res = (nq_q > ocs_pkg::Q_POS_MAX) ? ocs_pkg::SAT_HI
				: ocs_pkg::SAMPLE_W'(nq_q);
		end
	end

endmodule

/* rtl/core/overlap_crossfade_stitcher_unit.sv */
// Overlap crossfade stitcher: delay store of frames with linear crossfade of new batches.
// A crossfaded frame runs two serial blends, one per channel; full-store frames and drains
// also wait for the output register to be free before they are emitted.
// One frame in flight; the serial divide in ocs_blend sets the crossfade rate.
// Reset: store counters, batch state and error flag cleared, overlap register 4096;
// store contents are not cleared. Depends on ocs_pkg, ocs_if, ocs_ram, ocs_blend.
module overlap_crossfade_stitcher_unit #(
	parameter int MAX_OVERLAP = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ocs_in_if.sink                     item,
	ocs_out_if.source                  result,
	input  logic                       cfg_we,
	input  logic [ocs_pkg::CFG_W-1:0]  cfg_wdata
);

	localparam int OW = $clog2(MAX_OVERLAP + 1);
	localparam int AW = $clog2(MAX_OVERLAP);
	localparam int EW = (OW > ocs_pkg::CFG_W) ? OW : ocs_pkg::CFG_W;
	localparam logic [OW-1:0] MAX_OCC   = OW'(MAX_OVERLAP);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_OVERLAP - 1);
	localparam logic [OW:0]   MAX_SUM   = (OW + 1)'(MAX_OVERLAP);
	localparam logic [EW-1:0] MAX_EFF   = EW'(MAX_OVERLAP);

	ocs_pkg::state_t state_q, state_d;
	ocs_pkg::mode_t  mode_q, mode_d;

	logic                                func_q, bs_q;
	logic signed [ocs_pkg::SAMPLE_W-1:0] smp_q [ocs_pkg::CHANNELS];
	logic signed [ocs_pkg::SAMPLE_W-1:0] old_q [ocs_pkg::CHANNELS];
	logic [OW-1:0]                       occ_q, fade_q, pos_q, idx_q;
	logic [AW-1:0]                       ptr_q, waddr_q;
	logic                                open_q, err_q, last_q;
	logic [ocs_pkg::CFG_W-1:0]           overlap_q;

	logic                                out_valid_q;
	logic signed [ocs_pkg::SAMPLE_W-1:0] out_ch0_q, out_ch1_q;
	logic                                out_last_q, out_err_q;

	logic [OW-1:0]  fade_n, pos_n;
	logic           want_blend, full;
	logic [EW-1:0]  eff;
	logic [OW:0]    wsum;
	logic [AW-1:0]  waddr_n, ptr_inc;
	logic           out_free, out_load, ram_we;
	logic [ocs_pkg::FRAME_W-1:0] rdata;
	ocs_pkg::bl_ctl_t bl_ctl;
	logic           bl_done;
	logic signed [ocs_pkg::SAMPLE_W-1:0] bl_nw, bl_old, bl_res;

	// decision terms for the registered request
	assign fade_n     = bs_q ? occ_q : fade_q;
	assign pos_n      = bs_q ? '0 : pos_q;
	assign want_blend = (pos_n < fade_n) && (occ_q != '0);
	assign eff        = (overlap_q == '0) ? EW'(1)
		: ((EW'(overlap_q) > MAX_EFF) ? MAX_EFF : EW'(overlap_q));
	assign full       = EW'(occ_q) >= eff;
	assign wsum       = (OW + 1)'(ptr_q) + (OW + 1)'(occ_q);
	assign waddr_n    = (wsum >= MAX_SUM) ? AW'(wsum - MAX_SUM) : AW'(wsum);
	assign ptr_inc    = (ptr_q == LAST_ADDR) ? '0 : ptr_q + 1'b1;
	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = (state_q == ocs_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ocs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mode_d        = mode_q;
		bl_ctl.start  = 1'b0;
		bl_ctl.ch_sel = 1'b0;
		out_load      = 1'b0;
		ram_we        = 1'b0;
		unique case (state_q)
			ocs_pkg::S_IDLE: begin
				if (item.valid) state_d = ocs_pkg::S_DECIDE;
			end
			ocs_pkg::S_DECIDE: begin
				if (func_q == ocs_pkg::FUNC_DRAIN) begin
					mode_d  = ocs_pkg::M_DRAIN;
					state_d = (occ_q == '0) ? ocs_pkg::S_IDLE : ocs_pkg::S_RDWAIT;
				end else if (want_blend) begin
					mode_d  = ocs_pkg::M_BLEND;
					state_d = ocs_pkg::S_RDWAIT;
				end else if (full) begin
					mode_d  = ocs_pkg::M_SWAP;
					state_d = ocs_pkg::S_RDWAIT;
				end else begin
					mode_d  = ocs_pkg::M_PUSH;
					state_d = ocs_pkg::S_WRITE;
				end
			end
			ocs_pkg::S_RDWAIT: begin
				unique case (mode_q)
					ocs_pkg::M_DRAIN: state_d = ocs_pkg::S_EMIT;
					ocs_pkg::M_BLEND: begin
						bl_ctl.start = 1'b1;
						state_d      = ocs_pkg::S_BLEND0;
					end
					default: state_d = ocs_pkg::S_WRITE;
				endcase
			end
			ocs_pkg::S_BLEND0: begin
				bl_ctl.ch_sel = 1'b1;
				if (bl_done) begin
					bl_ctl.start = 1'b1;
					state_d      = ocs_pkg::S_BLEND1;
				end
			end
			ocs_pkg::S_BLEND1: begin
				if (bl_done) state_d = ocs_pkg::S_WRITE;
			end
			ocs_pkg::S_WRITE: begin
				ram_we  = 1'b1;
				state_d = (mode_q == ocs_pkg::M_SWAP) ? ocs_pkg::S_EMIT : ocs_pkg::S_IDLE;
			end
			ocs_pkg::S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ocs_pkg::S_IDLE;
				end
			end
			default: state_d = ocs_pkg::S_IDLE;
		endcase
	end

	// store bookkeeping and batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ocs_pkg::M_PUSH;
			occ_q     <= '0;
			ptr_q     <= '0;
			fade_q    <= '0;
			pos_q     <= '0;
			open_q    <= 1'b0;
			err_q     <= 1'b0;
			overlap_q <= ocs_pkg::OVERLAP_RESET;
		end else begin
			mode_q <= mode_d;
			if (cfg_we) overlap_q <= cfg_wdata;
			if (state_q == ocs_pkg::S_DECIDE) begin
				// closing an open batch latches whether it stopped inside its fade
				if ((func_q == ocs_pkg::FUNC_DRAIN || bs_q) && open_q) begin
					err_q <= pos_q < fade_q;
				end
				if (func_q == ocs_pkg::FUNC_DRAIN) begin
					open_q <= 1'b0;
					fade_q <= '0;
					pos_q  <= '0;
					if (occ_q != '0) begin
						occ_q <= occ_q - 1'b1;
						ptr_q <= ptr_inc;
					end
				end else begin
					open_q <= 1'b1;
					fade_q <= fade_n;
					if (want_blend) begin
						pos_q <= pos_n + 1'b1;
						occ_q <= occ_q - 1'b1;
						ptr_q <= ptr_inc;
					end else begin
						pos_q <= (pos_n < MAX_OCC) ? pos_n + 1'b1 : pos_n;
						if (full) begin
							ptr_q <= ptr_inc;
						end else begin
							occ_q <= occ_q + 1'b1;
						end
					end
				end
			end
			if (state_q == ocs_pkg::S_WRITE && mode_q == ocs_pkg::M_BLEND) begin
				occ_q <= occ_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_q   <= item.func;
			bs_q     <= item.batch_start;
			smp_q[0] <= item.sample_ch0;
			smp_q[1] <= item.sample_ch1;
		end
		if (state_q == ocs_pkg::S_DECIDE) begin
			waddr_q <= waddr_n;
			idx_q   <= pos_n;
			last_q  <= (occ_q == OW'(1));
		end
		if (state_q == ocs_pkg::S_RDWAIT) begin
			old_q[0] <= rdata[ocs_pkg::SAMPLE_W-1:0];
			old_q[1] <= rdata[ocs_pkg::FRAME_W-1:ocs_pkg::SAMPLE_W];
		end
		if (bl_done && state_q == ocs_pkg::S_BLEND0) smp_q[0] <= bl_res;
		if (bl_done && state_q == ocs_pkg::S_BLEND1) smp_q[1] <= bl_res;
		if (out_load) begin
			out_ch0_q  <= old_q[0];
			out_ch1_q  <= old_q[1];
			out_last_q <= (mode_q == ocs_pkg::M_DRAIN) && last_q;
			out_err_q  <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.out_ch0           = out_ch0_q;
	assign result.out_ch1           = out_ch1_q;
	assign result.drain_last        = out_last_q;
	assign result.short_batch_error = out_err_q;

	ocs_ram #(
		.WIDTH (ocs_pkg::FRAME_W),
		.DEPTH (MAX_OVERLAP)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_q),
		.wdata ({smp_q[1], smp_q[0]}),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	// channel 0 starts straight from the read data, channel 1 from the held copy
	assign bl_nw  = bl_ctl.ch_sel ? smp_q[1] : smp_q[0];
	assign bl_old = bl_ctl.ch_sel ? old_q[1] : rdata[ocs_pkg::SAMPLE_W-1:0];

	ocs_blend #(
		.PW (OW)
	) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bl_ctl.start),
		.nw     (bl_nw),
		.old    (bl_old),
		.idx    (idx_q),
		.p      (fade_q),
		.done   (bl_done),
		.res    (bl_res)
	);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= MAX_OCC)
		else $error("store occupancy above depth");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= LAST_ADDR)
		else $error("oldest pointer out of range");

	a_blend_done: assert property (@(posedge clk) disable iff (!arst_n)
		bl_done |-> (state_q == ocs_pkg::S_BLEND0 || state_q == ocs_pkg::S_BLEND1))
		else $error("blend finished outside a blend step");

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q == ocs_pkg::S_DECIDE)
		else $error("accepted request not decoded");

	a_no_drain_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> mode_q != ocs_pkg::M_DRAIN)
		else $error("store written on a drain request");

endmodule

/* tb/testbench.sv */
// Self-checking bench for overlap_crossfade_stitcher_unit: drives input requests, predicts the
// emitted frames in a local model of the delay store and crossfade, compares every result.
// Depends on ocs_pkg, ocs_if and the unit itself.
module testbench;
	import ocs_pkg::*;

	localparam int DEPTH = 4096;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] ch0;
		logic signed [SAMPLE_W-1:0] ch1;
		logic                       last;
		logic                       err;
	} stitched_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	ocs_in_if  item_if();
	ocs_out_if res_if();

	overlap_crossfade_stitcher_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_if),
		.result   (res_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle percentages of the sender and the receiver
	int src_pct = 0;
	int snk_pct = 0;
	int errors = 0;

	// model of the delay store and batch state
	logic signed [SAMPLE_W-1:0] held0 [DEPTH];
	logic signed [SAMPLE_W-1:0] held1 [DEPTH];
	int unsigned fill = 0;
	int unsigned head = 0;
	int unsigned fade_len = 0;
	int unsigned batch_pos = 0;
	logic [CFG_W-1:0] overlap_reg = OVERLAP_RESET;
	bit batch_live = 1'b0;
	bit short_err = 1'b0;
	stitched_t due_q[$];

	// (new*idx + old*(p-idx)) / p, nearest with ties away from zero, then saturate
	function automatic logic signed [SAMPLE_W-1:0] fade_mix(int nw, int od, int idx, int p);
		longint num;
		longint q;
		bit neg;
		num = longint'(nw) * idx + longint'(od) * (p - idx);
		neg = num < 0;
		if (neg)
			num = -num;
		q = (2 * num + p) / (2 * longint'(p));
		if (neg)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[SAMPLE_W-1:0];
	endfunction

	function automatic void take_oldest(output logic signed [SAMPLE_W-1:0] c0, c1);
		c0 = held0[head];
		c1 = held1[head];
		head = (head + 1) % DEPTH;
		fill--;
	endfunction

	function automatic void append(logic signed [SAMPLE_W-1:0] c0, c1);
		int unsigned slot;
		slot = (head + fill) % DEPTH;
		if (fill >= DEPTH)
			return;
		held0[slot] = c0;
		held1[slot] = c1;
		fill++;
	endfunction

	function automatic void close_batch();
		if (batch_live)
			short_err = batch_pos < fade_len;
		batch_live = 1'b0;
	endfunction

	function automatic void queue_frame(logic signed [SAMPLE_W-1:0] c0, c1, logic last);
		stitched_t r;
		r.ch0 = c0;
		r.ch1 = c1;
		r.last = last;
		r.err = short_err;
		due_q.insert(due_q.size(), r);
	endfunction

	function automatic void stitch_step(logic fn, logic bs, logic signed [SAMPLE_W-1:0] s0, s1);
		logic signed [SAMPLE_W-1:0] o0, o1;
		int unsigned lim;
		if (fn == FUNC_DRAIN) begin
			close_batch();
			fade_len = 0;
			batch_pos = 0;
			if (fill == 0)
				return;
			take_oldest(o0, o1);
			queue_frame(o0, o1, fill == 0);
			return;
		end
		if (bs) begin
			close_batch();
			fade_len = fill;
			batch_pos = 0;
		end
		batch_live = 1'b1;
		if (batch_pos < fade_len && fill > 0) begin
			take_oldest(o0, o1);
			append(fade_mix(s0, o0, batch_pos, fade_len), fade_mix(s1, o1, batch_pos, fade_len));
			batch_pos++;
			return;
		end
		if (batch_pos < DEPTH)
			batch_pos++;
		lim = overlap_reg;
		if (lim < 1)
			lim = 1;
		if (lim > DEPTH)
			lim = DEPTH;
		if (fill >= lim) begin
			take_oldest(o0, o1);
			append(s0, s1);
			queue_frame(o0, o1, 1'b0);
		end else begin
			append(s0, s1);
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= snk_pct);
	end

	// results are checked before the request of the same edge is applied to the model
	always @(posedge clk) begin
		stitched_t want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (due_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got ch0 %0d ch1 %0d",
						$time, res_if.out_ch0, res_if.out_ch1);
				end else begin
					want = due_q.pop_front();
					check_field("out_ch0", want.ch0, res_if.out_ch0);
					check_field("out_ch1", want.ch1, res_if.out_ch1);
					check_field("drain_last", want.last, res_if.drain_last);
					check_field("short_batch_error", want.err, res_if.short_batch_error);
				end
			end
			if (item_if.valid && item_if.ready)
				stitch_step(item_if.func, item_if.batch_start, item_if.sample_ch0,
					item_if.sample_ch1);
		end
	end

	task automatic push_req(input logic fn, input logic bs,
			input logic signed [SAMPLE_W-1:0] s0, input logic signed [SAMPLE_W-1:0] s1);
		while ($urandom_range(99) < src_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.func <= fn;
		item_if.batch_start <= bs;
		item_if.sample_ch0 <= s0;
		item_if.sample_ch1 <= s1;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
	endtask

	// drop valid, let expected frames arrive, then cover the longest silent crossfade
	task automatic wait_quiet();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (due_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic set_overlap(input logic [CFG_W-1:0] v);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		overlap_reg = v;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return SAT_HI;
			1: return SAT_LO;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_overlap();
		case ($urandom_range(11))
			0: return '0;
			1: return '1;
			2: return 13'd4096;
			default: return CFG_W'($urandom_range(1, 8));
		endcase
	endfunction

	// reset overlap of 4096: nothing is emitted by frames, only by drains
	task automatic test_startup_defaults();
		push_req(FUNC_DRAIN, 1'b1, SAT_HI, SAT_LO);   // empty store, no result
		push_req(FUNC_FRAME, 1'b0, SAT_HI, SAT_LO);   // opens a batch with no fade
		push_req(FUNC_FRAME, 1'b0, SAT_LO, SAT_HI);
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);   // empties the store
	endtask

	task automatic test_crossfade_rounding();
		set_overlap(13'd2);
		push_req(FUNC_FRAME, 1'b1, SAT_HI, SAT_LO);
		push_req(FUNC_FRAME, 1'b0, SAT_LO, SAT_HI);
		push_req(FUNC_FRAME, 1'b1, 16'sd1, -16'sd2);  // idx 0 gives the held frame
		push_req(FUNC_FRAME, 1'b0, 16'sd1, -16'sd2);  // half-way ties, both signs
		push_req(FUNC_FRAME, 1'b0, 16'sd0, 16'sd0);   // full store emits
		push_req(FUNC_FRAME, 1'b1, -16'sd5, 16'sd5);  // batch ends inside its fade
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
		push_req(FUNC_FRAME, 1'b1, 16'sd7, 16'sd9);   // batch start on empty store
		push_req(FUNC_FRAME, 1'b1, 16'sd3, 16'sd4);   // clears the error flag
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
	endtask

	// overlap lowered below occupancy: store keeps its size
	task automatic test_overlap_lowered();
		set_overlap(13'd3);
		push_req(FUNC_FRAME, 1'b1, 16'sd100, -16'sd100);
		push_req(FUNC_FRAME, 1'b0, 16'sd200, -16'sd200);
		push_req(FUNC_FRAME, 1'b0, 16'sd300, -16'sd300);
		set_overlap(13'd1);
		push_req(FUNC_FRAME, 1'b0, 16'sd400, -16'sd400);
		repeat (4) push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
	endtask

	task automatic test_clamped_overlap();
		set_overlap(13'd0);
		push_req(FUNC_FRAME, 1'b1, 16'sd11, 16'sd12);
		push_req(FUNC_FRAME, 1'b0, 16'sd13, 16'sd14);
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
		set_overlap(13'h1FFF);
		push_req(FUNC_FRAME, 1'b1, 16'sd15, 16'sd16);
		push_req(FUNC_DRAIN, 1'b0, 16'sd0, 16'sd0);
	endtask

	// 16-frame store: fill it, overflow once, crossfade a short batch against it, drain
	task automatic test_full_store();
		set_overlap(13'd16);
		for (int i = 0; i <= 16; i++)
			push_req(FUNC_FRAME, i == 0, pick_sample(), pick_sample());
		for (int i = 0; i < 3; i++)
			push_req(FUNC_FRAME, i == 0, pick_sample(), pick_sample());
		for (int i = 0; i <= 16; i++)
			push_req(FUNC_DRAIN, 1'b0, pick_sample(), pick_sample());
	endtask

	task automatic test_random_traffic(input int src, input int snk, input int n_items);
		int sent;
		int next_cfg;
		int choice;
		int len;
		sent = 0;
		next_cfg = 0;
		src_pct = src;
		snk_pct = snk;
		while (sent < n_items) begin
			if (sent >= next_cfg) begin
				set_overlap(pick_overlap());
				next_cfg += 50;
			end
			choice = $urandom_range(99);
			if (choice < 65) begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++)
					push_req(FUNC_FRAME, (i == 0) && ($urandom_range(9) != 0),
						pick_sample(), pick_sample());
			end else if (choice < 85) begin
				len = $urandom_range(1, 5);
				repeat (len) push_req(FUNC_DRAIN, 1'($urandom), pick_sample(), pick_sample());
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) push_req(1'($urandom), 1'($urandom), pick_sample(), pick_sample());
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_if.valid <= 1'b0;
		item_if.func <= FUNC_FRAME;
		item_if.batch_start <= 1'b0;
		item_if.sample_ch0 <= '0;
		item_if.sample_ch1 <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_startup_defaults();
		test_crossfade_rounding();
		test_overlap_lowered();
		test_clamped_overlap();
		test_full_store();
		test_random_traffic(0, 0, 135);
		test_random_traffic(80, 0, 135);
		test_random_traffic(0, 80, 135);
		test_random_traffic(16, 16, 135);

		wait_quiet();
		if (errors == 0)
			$display("overlap_crossfade_stitcher_unit verification clean");
		else
			$display("overlap_crossfade_stitcher_unit verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("overlap_crossfade_stitcher_unit verification failed");
		$finish;
	end

endmodule
